// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, also checked through reset.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/tld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal line discipline package
// Character codes, status codes, register indexes, sequencer states and the
// result beat type.
// ----------------------------------------------------------------------------
package tld_pkg;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANONICAL_MODE = 2'd1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_CTL_D = 8'h04;
   localparam logic [7:0] CHAR_CTL_H = 8'h08;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_CTL_P = 8'h10;
   localparam logic [7:0] CHAR_CTL_T = 8'h14;
   localparam logic [7:0] CHAR_CTL_U = 8'h15;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] ERASE_MAX  = 8'hFF;

   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [2:0] STATUS_DATA     = 3'd0;
   localparam logic [2:0] STATUS_LINE_END = 3'd1;
   localparam logic [2:0] STATUS_EOF_USED = 3'd2;
   localparam logic [2:0] STATUS_EOF_KEPT = 3'd3;
   localparam logic [2:0] STATUS_EMPTY    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_KILL,
      ST_KCHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic [7:0] erase_count;
      logic       line_ready;
      logic       listing_request;
      logic [2:0] read_status;
      logic [7:0] read_data;
   } rsp_type;

endpackage

// ===== hdl/tld_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line store
// Character ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tld_store #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/terminal_line_discipline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal line discipline
// Canonical and raw keyboard input over a ring buffer, with line editing,
// echo and per-byte reads.
//
//   channel  direction  beat
//   req_     in         func, rx_char, first_of_read
//   rsp_     out        echo, erase count, line ready, listing, read status/data
//   csr_     in         register index, write data (ready always high)
//
// One item at a time under a small sequencer around the line store.
// Key items go from the accept state through exec to done; reads go through
// exec, one store read in read, then done, or straight to done when nothing is committed.
// Kill-line alternates kill and kill-check states until the commit point or a
// newline: one store read and compare per character.
// The next item is taken while a result waits; a second result stalls in done.
// Reset is synchronous; the store holds no reset value.
// ----------------------------------------------------------------------------
module terminal_line_discipline
   import tld_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_rx_char,
   input  logic                 req_first_of_read,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_echo_valid,
   output logic [7:0]           rsp_echo_char,
   output logic [7:0]           rsp_erase_count,
   output logic                 rsp_line_ready,
   output logic                 rsp_listing_request,
   output logic [2:0]           rsp_read_status,
   output logic [7:0]           rsp_read_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   localparam int IW   = $clog2(2 * BUFFER_DEPTH);
   localparam int AW   = $clog2(BUFFER_DEPTH);
   localparam int CW   = $clog2(BUFFER_DEPTH + 1);
   localparam int CWX  = (CW > 8) ? CW : 8;
   localparam int WRAP = 2 * BUFFER_DEPTH;

   function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
      return (idx == IW'(WRAP - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
      return (idx == '0) ? IW'(WRAP - 1) : idx - 1'b1;
   endfunction

   function automatic logic [AW-1:0] slot(input logic [IW-1:0] idx);
      return (idx >= IW'(BUFFER_DEPTH)) ? AW'(idx - IW'(BUFFER_DEPTH)) : AW'(idx);
   endfunction

   state_type      state_ff, state_in;
   logic [IW-1:0]  read_ff, read_in;
   logic [IW-1:0]  commit_ff, commit_in;
   logic [IW-1:0]  edit_ff, edit_in;
   logic           echo_en_ff, echo_en_in;
   logic           canon_ff, canon_in;
   logic           func_ff, func_in;
   logic [7:0]     char_ff, char_in;
   logic           first_ff, first_in;
   logic [CW-1:0]  ecnt_ff, ecnt_in;
   rsp_type        res_ff, res_in;
   rsp_type        out_ff, out_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [7:0]     wr_data;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;
   logic [IW:0]    used;
   logic [7:0]     key_char;
   logic [CWX-1:0] ecnt_ext;
   logic           out_free;

   tld_store #(.DEPTH(BUFFER_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign used = {1'b0, edit_ff} - {1'b0, read_ff}
               + ((edit_ff < read_ff) ? (IW+1)'(WRAP) : '0);
   assign key_char = (char_ff == CHAR_CR) ? CHAR_LF : char_ff;
   assign ecnt_ext = CWX'(ecnt_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_addr  = (func_ff == FUNC_READ) ? slot(read_ff) : slot(idx_dec(edit_ff));
   assign wr_addr  = slot(edit_ff);
   assign wr_data  = key_char;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (func_ff == FUNC_READ) begin
               state_in = (read_ff == commit_ff) ? ST_DONE : ST_READ;
            end else if (canon_ff && char_ff == CHAR_CTL_U) begin
               state_in = ST_KILL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_KILL: state_in = (edit_ff == commit_ff) ? ST_DONE : ST_KCHK;
         ST_KCHK: state_in = (rd_data == CHAR_LF) ? ST_DONE : ST_KILL;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      read_in      = read_ff;
      commit_in    = commit_ff;
      edit_in      = edit_ff;
      echo_en_in   = echo_en_ff;
      canon_in     = canon_ff;
      func_in      = func_ff;
      char_in      = char_ff;
      first_in     = first_ff;
      ecnt_in      = ecnt_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;

      if (csr_valid) begin
         if (csr_index == CSR_ECHO_ENABLE) begin
            echo_en_in = csr_wdata;
         end else if (csr_index == CSR_CANONICAL_MODE) begin
            canon_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            func_in  = req_func;
            char_in  = req_rx_char;
            first_in = req_first_of_read;
            ecnt_in  = '0;
            res_in   = '0;
         end
         ST_EXEC: begin
            if (func_ff == FUNC_READ) begin
               if (read_ff == commit_ff) begin
                  res_in.read_status = STATUS_EMPTY;
               end
            end else if (canon_ff && char_ff == CHAR_CTL_T) begin
               res_in = '0;
            end else if (canon_ff && char_ff == CHAR_CTL_P) begin
               res_in.listing_request = 1'b1;
            end else if (canon_ff && char_ff == CHAR_CTL_U) begin
               res_in = '0;
            end else if (canon_ff && (char_ff == CHAR_CTL_H || char_ff == CHAR_DEL)) begin
               if (edit_ff != commit_ff) begin
                  edit_in = idx_dec(edit_ff);
                  ecnt_in = CW'(1);
               end
            end else if (key_char != CHAR_NUL && used < (IW+1)'(BUFFER_DEPTH)) begin
               wr_en   = 1'b1;
               edit_in = idx_inc(edit_ff);
               if (!canon_ff || key_char == CHAR_LF || key_char == CHAR_CTL_D
                   || used == (IW+1)'(BUFFER_DEPTH - 1)) begin
                  commit_in         = idx_inc(edit_ff);
                  res_in.line_ready = 1'b1;
               end
               if (echo_en_ff) begin
                  res_in.echo_valid = 1'b1;
                  res_in.echo_char  = key_char;
               end
            end
         end
         ST_READ: begin
            if (canon_ff && rd_data == CHAR_CTL_D) begin
               if (first_ff) begin
                  read_in            = idx_inc(read_ff);
                  res_in.read_status = STATUS_EOF_USED;
               end else begin
                  res_in.read_status = STATUS_EOF_KEPT;
               end
            end else begin
               read_in            = idx_inc(read_ff);
               res_in.read_data   = rd_data;
               res_in.read_status = (canon_ff && rd_data == CHAR_LF)
                                    ? STATUS_LINE_END : STATUS_DATA;
            end
         end
         ST_KILL: begin
            res_in = res_ff;
         end
         ST_KCHK: begin
            if (rd_data != CHAR_LF) begin
               edit_in = idx_dec(edit_ff);
               ecnt_in = ecnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in = res_ff;
               if (!echo_en_ff) begin
                  out_in.erase_count = '0;
               end else if (ecnt_ext > CWX'(ERASE_MAX)) begin
                  out_in.erase_count = ERASE_MAX;
               end else begin
                  out_in.erase_count = ecnt_ext[7:0];
               end
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_ff      <= '0;
         commit_ff    <= '0;
         edit_ff      <= '0;
         echo_en_ff   <= 1'b1;
         canon_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
         echo_en_ff   <= echo_en_in;
         canon_ff     <= canon_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      char_ff  <= char_in;
      first_ff <= first_in;
      ecnt_ff  <= ecnt_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_echo_valid      = out_ff.echo_valid;
   assign rsp_echo_char       = out_ff.echo_char;
   assign rsp_erase_count     = out_ff.erase_count;
   assign rsp_line_ready      = out_ff.line_ready;
   assign rsp_listing_request = out_ff.listing_request;
   assign rsp_read_status     = out_ff.read_status;
   assign rsp_read_data       = out_ff.read_data;

endmodule

// ===== hdl/tld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal line discipline checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tld_checker
   import tld_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_echo_valid,
   input logic [7:0] rsp_echo_char,
   input logic [2:0] rsp_read_status,
   input logic [7:0] rsp_read_data
);

   `ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, reset, !rsp_valid)
   `ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_echo_char) && $stable(rsp_read_status) && $stable(rsp_read_data))
   `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `ASSERT_SAME(a_status_range, rsp_valid, rsp_read_status <= STATUS_EMPTY)
   `ASSERT_SAME(a_echo_is_key, rsp_valid && rsp_echo_valid, rsp_read_status == STATUS_DATA && rsp_read_data == 8'h00)

endmodule

bind terminal_line_discipline tld_checker u_tld_checker (.*);
